// File: sv/dstm_pkg.sv
// Shared types, widths and constants of the disk service time model.
package dstm_pkg;

  localparam int TimeBitsDef = 48;

  localparam int AddrW    = 32;
  localparam int NowW     = 48;
  localparam int OutW     = 48;
  localparam int HpcW     = 8;
  localparam int SptW     = 12;
  localparam int TpsW     = 24;
  localparam int TickW    = 32;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 3;
  localparam int TrackW   = HpcW + SptW;
  localparam int MoveW    = SptW + 1;
  localparam int ProdW    = MoveW + TpsW;
  localparam int RawW     = ProdW + 1;

  localparam logic [HpcW-1:0]  HpcRst  = HpcW'(4);
  localparam logic [SptW-1:0]  SptRst  = SptW'(63);
  localparam logic [TpsW-1:0]  TpsRst  = TpsW'(1000);
  localparam logic [TickW-1:0] TickRst = '0;
  localparam logic [AddrW-1:0] ParkRst = '0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADS      = 3'd0,
    CFG_SECTORS    = 3'd1,
    CFG_TICKS      = 3'd2,
    CFG_RD_SEEK    = 3'd3,
    CFG_WR_SEEK    = 3'd4,
    CFG_RD_OVH     = 3'd5,
    CFG_WR_OVH     = 3'd6,
    CFG_PARK       = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_CYL,
    DIV_DST,
    DIV_TQ,
    DIV_CUR
  } div_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CYL_GO,
    ST_CYL_WAIT,
    ST_DST_GO,
    ST_DST_WAIT,
    ST_TQ_GO,
    ST_TQ_WAIT,
    ST_CUR_GO,
    ST_CUR_WAIT,
    ST_MOVE,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic    capture;
    logic    div_start;
    logic    div_take;
    div_op_e div_op;
    logic    move_en;
    logic    mul_en;
    logic    sum_en;
    logic    finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: sv/disk_service_time_model_core.sv
// Disk service time model: top level joining the sequencer and the datapath.
//
// Input channel: in_valid_i / in_stall_o carry one request item (block address,
// mode, current time). Output channel: out_valid_o / out_stall_i carry one
// result item (service ticks, completion delay) per request. An item moves at
// a clock edge where valid is high and stall is low.
// Configuration: cfg_we_i writes cfg_data_i into the register cfg_idx_i (a park
// write is ignored); write only while no request is in flight.
// Each request runs four divisions on a shared one-bit-per-cycle divider,
// then move, multiply, sum and finish steps, from accept to result.
// Throughput: one request at a time; the next is accepted only once the
// sequencer is back in idle after the previous result is loaded into the output register.
// Reset: registers return to defaults, the arm rests at cylinder zero and the
// disk is idle at time zero.
// Receiver stall: the result holds in the output register; a finished request
// waits in its last step until the register frees up.
module disk_service_time_model_core import dstm_pkg::*; #(
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [AddrW-1:0]    block_address_i,
  input  logic                mode_i,
  input  logic [NowW-1:0]     now_ticks_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OutW-1:0]     service_ticks_o,
  output logic [OutW-1:0]     completion_delay_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  dstm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_stall_o(in_stall_o)
  );

  dstm_dp #(
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .block_address_i   (block_address_i),
    .mode_i            (mode_i),
    .now_ticks_i       (now_ticks_i),
    .out_stall_i       (out_stall_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .service_ticks_o   (service_ticks_o),
    .completion_delay_o(completion_delay_o)
  );

endmodule

// File: sv/dstm_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module dstm_div import dstm_pkg::*; #(
  parameter int DW = TimeBitsDef,
  parameter int VW = TpsW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int CntW = $clog2(DW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   rem_q;
  logic [VW-1:0]   dvs_q;

  logic [VW:0]     shifted;
  logic [VW:0]     diff;
  logic            ge;
  logic [VW-1:0]   rem_d;

  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
    rem_d   = ge ? diff[VW-1:0] : shifted[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: sv/dstm_ctrl.sv
// Sequencer that steps one request through the divider, multiplier and sums.
module dstm_ctrl import dstm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o,
  output logic      in_stall_o
);

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_CYL_GO;
      ST_CYL_GO:   state_d = ST_CYL_WAIT;
      ST_CYL_WAIT: if (sts_i.div_done) state_d = ST_DST_GO;
      ST_DST_GO:   state_d = ST_DST_WAIT;
      ST_DST_WAIT: if (sts_i.div_done) state_d = ST_TQ_GO;
      ST_TQ_GO:    state_d = ST_TQ_WAIT;
      ST_TQ_WAIT:  if (sts_i.div_done) state_d = ST_CUR_GO;
      ST_CUR_GO:   state_d = ST_CUR_WAIT;
      ST_CUR_WAIT: if (sts_i.div_done) state_d = ST_MOVE;
      ST_MOVE:     state_d = ST_MUL;
      ST_MUL:      state_d = ST_SUM;
      ST_SUM:      state_d = ST_DONE;
      ST_DONE:     if (sts_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_op = DIV_CYL;
    unique case (state_q)
      ST_IDLE:     cmd_o.capture = in_valid_i;
      ST_CYL_GO:   cmd_o.div_start = 1'b1;
      ST_CYL_WAIT: cmd_o.div_take = sts_i.div_done;
      ST_DST_GO: begin
        cmd_o.div_op    = DIV_DST;
        cmd_o.div_start = 1'b1;
      end
      ST_DST_WAIT: begin
        cmd_o.div_op   = DIV_DST;
        cmd_o.div_take = sts_i.div_done;
      end
      ST_TQ_GO: begin
        cmd_o.div_op    = DIV_TQ;
        cmd_o.div_start = 1'b1;
      end
      ST_TQ_WAIT: begin
        cmd_o.div_op   = DIV_TQ;
        cmd_o.div_take = sts_i.div_done;
      end
      ST_CUR_GO: begin
        cmd_o.div_op    = DIV_CUR;
        cmd_o.div_start = 1'b1;
      end
      ST_CUR_WAIT: begin
        cmd_o.div_op   = DIV_CUR;
        cmd_o.div_take = sts_i.div_done;
      end
      ST_MOVE:     cmd_o.move_en = 1'b1;
      ST_MUL:      cmd_o.mul_en = 1'b1;
      ST_SUM:      cmd_o.sum_en = 1'b1;
      ST_DONE:     cmd_o.finish = sts_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// File: sv/dstm_dp.sv
// Datapath: configuration registers, disk state, divider, multiplier and result register.
module dstm_dp import dstm_pkg::*; #(
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [AddrW-1:0]    block_address_i,
  input  logic                mode_i,
  input  logic [NowW-1:0]     now_ticks_i,
  input  logic                out_stall_i,
  input  ctrl_cmd_t           cmd_i,
  output ctrl_sts_t           sts_o,
  output logic                out_valid_o,
  output logic [OutW-1:0]     service_ticks_o,
  output logic [OutW-1:0]     completion_delay_o
);

  localparam logic [TIME_BITS-1:0] TMax = '1;
  localparam int NwW  = (TIME_BITS > NowW) ? TIME_BITS : NowW;
  localparam int SumW = (TIME_BITS > RawW) ? TIME_BITS : RawW;

  logic [HpcW-1:0]  hpc_q;
  logic [SptW-1:0]  spt_q;
  logic [TpsW-1:0]  tps_q;
  logic [TickW-1:0] rd_seek_q;
  logic [TickW-1:0] wr_seek_q;
  logic [TickW-1:0] rd_ovh_q;
  logic [TickW-1:0] wr_ovh_q;

  logic [HpcW-1:0]  hpc_eff;
  logic [SptW-1:0]  spt_eff;
  logic [TpsW-1:0]  tps_eff;

  logic [AddrW-1:0]     lba_q;
  logic                 mode_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TrackW-1:0]    track_q;
  logic [AddrW-1:0]     cyl_q;
  logic [MoveW-1:0]     dest_q;
  logic [TIME_BITS-1:0] tq_q;
  logic [SptW-1:0]      cur_q;
  logic [MoveW-1:0]     move_q;
  logic [ProdW-1:0]     prod_q;
  logic [TIME_BITS-1:0] svc_q;
  logic [TIME_BITS-1:0] start_q;

  logic [AddrW-1:0]     arm_q;
  logic [TIME_BITS-1:0] busy_q;

  logic                 out_valid_q;
  logic [OutW-1:0]      service_q;
  logic [OutW-1:0]      delay_q;

  logic [NwW-1:0]       now_ext;
  logic [TIME_BITS-1:0] now_c;
  logic [TIME_BITS-1:0] div_dividend;
  logic [TpsW-1:0]      div_divisor;
  logic                 div_done;
  logic [TIME_BITS-1:0] div_quot;
  logic [TpsW-1:0]      div_rem;
  logic [MoveW-1:0]     cur_ext;
  logic [MoveW-1:0]     spt_ext;
  logic [MoveW-1:0]     move_d;
  logic [TickW-1:0]     seek_sel;
  logic [TickW-1:0]     ovh_sel;
  logic [RawW-1:0]      raw_sum;
  logic [SumW-1:0]      raw_ext;
  logic [TIME_BITS-1:0] svc_d;
  logic [TIME_BITS-1:0] start_d;
  logic [TIME_BITS:0]   done_sum;
  logic [TIME_BITS-1:0] done_c;
  logic [TIME_BITS-1:0] delay_c;
  logic                 out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpc_q     <= HpcRst;
      spt_q     <= SptRst;
      tps_q     <= TpsRst;
      rd_seek_q <= TickRst;
      wr_seek_q <= TickRst;
      rd_ovh_q  <= TickRst;
      wr_ovh_q  <= TickRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HEADS:   hpc_q     <= cfg_data_i[HpcW-1:0];
        CFG_SECTORS: spt_q     <= cfg_data_i[SptW-1:0];
        CFG_TICKS:   tps_q     <= cfg_data_i[TpsW-1:0];
        CFG_RD_SEEK: rd_seek_q <= cfg_data_i[TickW-1:0];
        CFG_WR_SEEK: wr_seek_q <= cfg_data_i[TickW-1:0];
        CFG_RD_OVH:  rd_ovh_q  <= cfg_data_i[TickW-1:0];
        CFG_WR_OVH:  wr_ovh_q  <= cfg_data_i[TickW-1:0];
        // park position matters only at reset, which restores its default
        CFG_PARK:    ;
        default:     ;
      endcase
    end
  end

  always_comb begin
    hpc_eff = (hpc_q == '0) ? HpcW'(1) : hpc_q;
    spt_eff = (spt_q == '0) ? SptW'(1) : spt_q;
    tps_eff = (tps_q == '0) ? TpsW'(1) : tps_q;
    now_ext = NwW'(now_ticks_i);
    now_c   = (now_ext > NwW'(TMax)) ? TMax : TIME_BITS'(now_ext);
  end

  always_comb begin
    div_dividend = TIME_BITS'(lba_q);
    div_divisor  = TpsW'(track_q);
    unique case (cmd_i.div_op)
      DIV_CYL: begin
        div_dividend = TIME_BITS'(lba_q);
        div_divisor  = TpsW'(track_q);
      end
      DIV_DST: begin
        div_dividend = TIME_BITS'(lba_q);
        div_divisor  = TpsW'(spt_eff);
      end
      DIV_TQ: begin
        div_dividend = now_q;
        div_divisor  = tps_eff;
      end
      DIV_CUR: begin
        div_dividend = tq_q;
        div_divisor  = TpsW'(spt_eff);
      end
      default: ;
    endcase
  end

  dstm_div #(
    .DW(TIME_BITS),
    .VW(TpsW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  always_comb begin
    cur_ext = MoveW'(cur_q);
    spt_ext = MoveW'(spt_eff);
    if (cur_ext < dest_q) begin
      move_d = dest_q - cur_ext;
    end else if (cur_ext > dest_q) begin
      move_d = spt_ext - cur_ext + dest_q;
    end else begin
      move_d = '0;
    end
    seek_sel = mode_q ? rd_seek_q : wr_seek_q;
    ovh_sel  = mode_q ? rd_ovh_q : wr_ovh_q;
    raw_sum  = RawW'(ovh_sel) + RawW'(prod_q) + RawW'(tps_eff)
             + ((cyl_q != arm_q) ? RawW'(seek_sel) : RawW'(0));
    raw_ext  = SumW'(raw_sum);
    svc_d    = (raw_ext > SumW'(TMax)) ? TMax : TIME_BITS'(raw_ext);
    start_d  = (busy_q > now_q) ? busy_q : now_q;
    done_sum = {1'b0, start_q} + {1'b0, svc_q};
    done_c   = done_sum[TIME_BITS] ? TMax : done_sum[TIME_BITS-1:0];
    delay_c  = done_c - now_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lba_q   <= block_address_i;
      mode_q  <= mode_i;
      now_q   <= now_c;
      track_q <= TrackW'(hpc_eff) * TrackW'(spt_eff);
    end
    if (cmd_i.div_take) begin
      unique case (cmd_i.div_op)
        DIV_CYL: cyl_q  <= div_quot[AddrW-1:0];
        DIV_DST: dest_q <= MoveW'(div_rem[SptW-1:0]) + MoveW'(1);
        DIV_TQ:  tq_q   <= div_quot;
        DIV_CUR: cur_q  <= div_rem[SptW-1:0];
        default: ;
      endcase
    end
    if (cmd_i.move_en) begin
      move_q <= move_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= ProdW'(move_q) * ProdW'(tps_eff);
    end
    if (cmd_i.sum_en) begin
      svc_q   <= svc_d;
      start_q <= start_d;
    end
    if (cmd_i.finish) begin
      service_q <= OutW'(svc_q);
      delay_q   <= OutW'(delay_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_q       <= ParkRst;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        arm_q       <= cyl_q;
        busy_q      <= done_c;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o          = '0;
    sts_o.div_done = div_done;
    sts_o.out_free = out_free;
  end

  assign out_valid_o        = out_valid_q;
  assign service_ticks_o    = service_q;
  assign completion_delay_o = delay_q;

endmodule

// File: tb/disk_service_time_model_core_tb.sv
// Self-checking testbench for disk_service_time_model_core against an in-bench timing model.
`timescale 1ns / 1ps

module disk_service_time_model_core_tb;
  import dstm_pkg::*;

  localparam longint unsigned TimeMax    = (64'd1 << TimeBitsDef) - 1;
  localparam logic            ModeRead   = 1'b1;
  localparam logic            ModeWrite  = 1'b0;
  localparam int              CycleLimit = 1_200_000;
  localparam int              DrainWait  = 250;

  typedef struct {
    logic [AddrW-1:0] addr;
    logic             mode;
    logic [NowW-1:0]  now;
  } req_t;

  typedef struct {
    logic [OutW-1:0] service;
    logic [OutW-1:0] delay;
  } times_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [AddrW-1:0]    block_address_i = '0;
  logic                mode_i = 1'b0;
  logic [NowW-1:0]     now_ticks_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [OutW-1:0]     service_ticks_o;
  logic [OutW-1:0]     completion_delay_o;

  // register copies and disk state
  logic [HpcW-1:0]  heads_r;
  logic [SptW-1:0]  sectors_r;
  logic [TpsW-1:0]  ticks_r;
  logic [TickW-1:0] rd_seek_r, wr_seek_r, rd_ovh_r, wr_ovh_r, park_r;
  longint unsigned  arm_cyl;
  longint unsigned  busy_until;

  req_t   request_q[$];
  times_t access_times_q[$];
  req_t   next_req, took_req;
  times_t want;

  int n_queued, n_accepted, n_checked, n_errors, n_cycles;
  int n_reads, n_seeks, n_saturated, n_settings;
  int in_gap_max, out_gap_max, gap_left, hold_left;
  longint unsigned t_base, gen_cyl;

  disk_service_time_model_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .block_address_i,
    .mode_i,
    .now_ticks_i,
    .out_valid_o,
    .out_stall_i,
    .service_ticks_o,
    .completion_delay_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint unsigned geom(logic [TpsW-1:0] v);
    return (v == 0) ? 64'd1 : longint'(v);
  endfunction

  function automatic times_t compute_access_times(req_t r);
    longint unsigned spt, tps, track, cyl, dest, cur, move, svc, nowv, start, done;
    times_t t;
    spt   = geom(TpsW'(sectors_r));
    tps   = geom(ticks_r);
    track = geom(TpsW'(heads_r)) * spt;
    cyl   = longint'(r.addr) / track;
    dest  = (longint'(r.addr) % track) % spt + 1;
    nowv  = r.now;
    if (nowv > TimeMax) nowv = TimeMax;
    svc = 0;
    if (cyl != arm_cyl) begin
      svc = r.mode ? rd_seek_r : wr_seek_r;
      n_seeks++;
    end
    svc += r.mode ? rd_ovh_r : wr_ovh_r;
    cur = (nowv / tps) % spt;
    if (cur < dest) move = dest - cur;
    else if (cur > dest) move = spt - cur + dest;
    else move = 0;
    svc += move * tps + tps;
    if (svc > TimeMax) svc = TimeMax;
    arm_cyl = cyl;
    start = (busy_until > nowv) ? busy_until : nowv;
    done = (svc > TimeMax - start) ? TimeMax : start + svc;
    if (done == TimeMax) n_saturated++;
    busy_until = done;
    if (r.mode) n_reads++;
    t.service = OutW'(svc & TimeMax);
    t.delay   = OutW'((done - nowv) & TimeMax);
    return t;
  endfunction

  task automatic log_error(string what, logic [OutW-1:0] exp_v, logic [OutW-1:0] act_v);
    n_errors++;
    if (n_errors <= 10)
      $display("ERROR %s: expected %0h, got %0h (result %0d)", what, exp_v, act_v, n_checked);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        took_req.addr = block_address_i;
        took_req.mode = mode_i;
        took_req.now  = now_ticks_i;
        access_times_q.push_back(compute_access_times(took_req));
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          next_req = request_q.pop_front();
          block_address_i <= next_req.addr;
          mode_i          <= next_req.mode;
          now_ticks_i     <= next_req.now;
          in_valid_i      <= 1'b1;
          gap_left = $urandom_range(0, in_gap_max);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (access_times_q.size() == 0) begin
          log_error("result with no request outstanding", '0, service_ticks_o);
        end else begin
          want = access_times_q.pop_front();
          if (service_ticks_o !== want.service)
            log_error("service_ticks", want.service, service_ticks_o);
          if (completion_delay_o !== want.delay)
            log_error("completion_delay", want.delay, completion_delay_o);
          n_checked++;
        end
        hold_left = $urandom_range(0, out_gap_max);
      end else if (hold_left != 0 && out_valid_o) begin
        hold_left--;
      end
      out_stall_i <= (hold_left != 0);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HEADS:   heads_r   = data[HpcW-1:0];
      CFG_SECTORS: sectors_r = data[SptW-1:0];
      CFG_TICKS:   ticks_r   = data[TpsW-1:0];
      CFG_RD_SEEK: rd_seek_r = data;
      CFG_WR_SEEK: wr_seek_r = data;
      CFG_RD_OVH:  rd_ovh_r  = data;
      CFG_WR_OVH:  wr_ovh_r  = data;
      CFG_PARK:    park_r    = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [31:0] hpc, logic [31:0] spt, logic [31:0] tps,
                               logic [31:0] rs, logic [31:0] ws, logic [31:0] ro,
                               logic [31:0] wo, logic [31:0] park);
    write_reg(CFG_HEADS, hpc);
    write_reg(CFG_SECTORS, spt);
    write_reg(CFG_TICKS, tps);
    write_reg(CFG_RD_SEEK, rs);
    write_reg(CFG_WR_SEEK, ws);
    write_reg(CFG_RD_OVH, ro);
    write_reg(CFG_WR_OVH, wo);
    write_reg(CFG_PARK, park);
    n_settings++;
  endtask

  task automatic add_request(logic [AddrW-1:0] addr, logic mode, longint unsigned now);
    req_t r;
    r.addr = addr;
    r.mode = mode;
    r.now  = NowW'(now);
    request_q.push_back(r);
    n_queued++;
  endtask

  // wait for every result, then re-draw the pacing of both sides
  task automatic settle();
    wait (n_checked == n_queued);
    in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 4;
    out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
  endtask

  function automatic logic [31:0] rand_reg();
    return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64);
  endfunction

  task automatic add_random(int count, bit wide);
    longint unsigned spt, tps, track, cyl, lba, dest, rev, nowv, adv, mask;
    int kind;
    repeat (count) begin
      spt   = geom(TpsW'(sectors_r));
      tps   = geom(ticks_r);
      track = geom(TpsW'(heads_r)) * spt;
      kind  = $urandom_range(0, 9);
      if (kind < 5) begin
        cyl = $urandom_range(0, 1) ? gen_cyl : gen_cyl + $urandom_range(1, 3);
        lba = cyl * track + $urandom_range(0, 32'(track - 1));
        if (lba > 64'hFFFF_FFFF) lba = $urandom;
      end else if (kind < 8) begin
        lba = $urandom_range(0, 32'(4 * track));
      end else begin
        lba = $urandom;
      end
      gen_cyl = lba / track;
      mask = (64'd1 << $urandom_range(0, 34)) - 1;
      adv  = ($urandom_range(0, 3) == 0) ? 0 : ({$urandom, $urandom} & mask);
      t_base += adv;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        // land exactly on the target sector
        dest = (lba % track) % spt + 1;
        rev  = spt * tps;
        t_base = (t_base / rev + 1) * rev + (dest - 1) * tps + $urandom_range(0, 32'(tps - 1));
        nowv = t_base;
      end else if (kind < 3) begin
        adv  = $urandom_range(0, 100000);
        nowv = (t_base > adv) ? t_base - adv : 0;
      end else begin
        nowv = t_base;
      end
      if (wide && $urandom_range(0, 1)) nowv = {$urandom, $urandom} & TimeMax;
      if (t_base > TimeMax) t_base = TimeMax;
      if (nowv > TimeMax) nowv = TimeMax;
      add_request(32'(lba), $urandom_range(0, 1) ? ModeRead : ModeWrite, nowv);
    end
  endtask

  initial begin
    while (n_cycles < CycleLimit) @(posedge clk_i) n_cycles++;
    $display("timeout after %0d cycles, %0d of %0d results", n_cycles, n_checked, n_queued);
    $display("disk_service_time_model_core_tb failed");
    $finish;
  end

  initial begin
    heads_r = HpcRst;  sectors_r = SptRst;  ticks_r = TpsRst;
    rd_seek_r = TickRst;  wr_seek_r = TickRst;  rd_ovh_r = TickRst;  wr_ovh_r = TickRst;
    park_r = ParkRst;
    arm_cyl = 0;  busy_until = 0;  t_base = 0;  gen_cyl = 0;
    in_gap_max = 4;  out_gap_max = 4;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults; park written now must not move the arm
    write_reg(CFG_PARK, 3);
    write_reg(CFG_RD_SEEK, 500);
    write_reg(CFG_WR_SEEK, 700);
    n_settings++;
    add_request(0, ModeRead, 0);
    add_request(300, ModeWrite, 500);
    add_request(0, ModeRead, 1000);
    add_request(0, ModeWrite, 62500);
    add_random(40, 1'b0);
    settle();

    apply_setting(2, 8, 16, 100, 300, 7, 11, 5);
    t_base = 0;
    add_request(0, ModeWrite, 0);
    add_request(0, ModeRead, 16);
    add_request(7, ModeWrite, 1000);
    add_request(16, ModeRead, 2000);
    add_request(16, ModeWrite, 2000);
    add_request(32, ModeWrite, 3000);
    add_request(32'hFFFF_FFFF, ModeRead, 4000);
    add_request(0, ModeRead, 64'h0000_FFFF_FFFF);
    t_base = 64'h0001_0000_0000;
    add_random(280, 1'b0);
    settle();

    apply_setting(32'hFF, 32'hFFF, 32'hFF_FFFF, '1, '1, '1, '1, '1);
    add_request(0, ModeRead, t_base);
    add_request(32'hFFFF_FFFF, ModeWrite, t_base);
    add_random(150, 1'b0);
    settle();

    apply_setting(1, 1, 1, 0, 0, 0, 0, 0);
    add_request(32'hFFFF_FFFF, ModeWrite, t_base);
    add_random(150, 1'b0);
    settle();

    // zero geometry, upper data bits set
    apply_setting(32'hABCD_EF00, 32'h1234_5000, 32'hFF00_0000, 9, 13, 2, 3, 0);
    add_random(100, 1'b0);
    settle();

    repeat (6) begin
      apply_setting(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                    rand_reg(), rand_reg(), rand_reg());
      add_random(120, 1'b0);
      settle();
    end

    // times near the top of the range, completion saturates
    apply_setting(16, 255, 4000, 32'h8000_0000, 32'h7FFF_FFFF, 12, 34, 99);
    t_base = TimeMax - (64'd1 << 36);
    add_random(100, 1'b1);
    add_request(1234, ModeRead, TimeMax);
    add_request(1234, ModeWrite, TimeMax - 1);
    add_request(0, ModeRead, 0);
    add_request(32'hFFFF_FFFF, ModeWrite, TimeMax);
    settle();

    repeat (DrainWait) @(posedge clk_i);
    $display("%0d requests (%0d reads, %0d cylinder changes) under %0d register settings",
             n_checked, n_reads, n_seeks, n_settings);
    $display("%0d completions saturated, %0d mismatches", n_saturated, n_errors);
    if (n_errors == 0 && access_times_q.size() == 0 && n_accepted == n_queued) begin
      $display("disk_service_time_model_core_tb passed");
    end else begin
      $display("disk_service_time_model_core_tb failed");
    end
    $finish;
  end

endmodule

// File: disk_service_time_model_core.f
sv/dstm_pkg.sv
sv/dstm_div.sv
sv/dstm_ctrl.sv
sv/dstm_dp.sv
sv/disk_service_time_model_core.sv
tb/disk_service_time_model_core_tb.sv
